// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: operation and
// status codes, the stored entry and the result item.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 7;
    localparam int OCC_W  = 5;

    localparam logic [PRIO_W-1:0] PRIO_MAX = 7'd100;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // One stored entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // One result item
    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

endpackage

// File: hdl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels of the queue: request items in, result items out.
// ----------------------------------------------------------------------------
interface spq_in_if;
    import spq_pkg::*;
    logic               valid;
    logic               ready;
    logic               op;
    logic [ID_W-1:0]    process_id;
    logic [PRIO_W-1:0]  priority_req;

    modport source (output valid, op, process_id, priority_req, input ready);
    modport sink   (input valid, op, process_id, priority_req, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [ID_W-1:0]    out_id;
    logic [PRIO_W-1:0]  out_priority;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, status, out_id, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_id, out_priority, occupancy, output ready);
endinterface

// File: hdl/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  spq_pkg::t_entry           i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output spq_pkg::t_entry           o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Priority-ordered scheduler queue with arrival order kept among equals.
// ----------------------------------------------------------------------------
// Entries sit in a circular buffer in one memory, highest priority at the
// head. A dequeue reads the head entry. An enqueue walks back from the tail,
// one stored entry per cycle through the memory's single read port, moving
// each lower-priority entry up by one slot until its place is found; at
// most QUEUE_DEPTH - 1 entries are moved, since a full queue drops the
// item. Full and empty cases skip the memory. A result waits in S_OUT
// while the previous result is still held in the output register. One
// request item is worked on at a time; a new one is accepted while the
// previous result still waits in the output register. Priorities above
// 100 are stored as 100. The memory is not cleared after reset; only slots
// holding live entries are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEQ  = 5'b00010,
        S_INS  = 5'b00100,
        S_PUT  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_ADDR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? LAST_ADDR : p - 1'b1;
    endfunction

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [AW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_rem, n_rem;
    t_entry             r_new, n_new;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    t_entry             w_wdata, w_rdata;
    logic [PRIO_W-1:0]  w_prio_sat;
    logic [CW-1:0]      w_count_inc;

    spq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_prio_sat  = (i_in.priority_req > PRIO_MAX) ? PRIO_MAX : i_in.priority_req;
    assign w_count_inc = r_count + 1'b1;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.out_id       = r_out.id;
    assign o_out.out_priority = r_out.prio;
    assign o_out.occupancy    = r_out.occupancy;

    // Sequencer: accept, walk the memory, form the result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_new       = r_new;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_new;
        w_re        = 1'b0;
        w_raddr     = ptr_dec(r_pos);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.op == OP_ENQ) begin
                        n_new.id   = i_in.process_id;
                        n_new.prio = w_prio_sat;
                        if (r_count == FULL_CNT) begin
                            n_res   = '{ST_FULL, '0, '0, OCC_W'(r_count)};
                            n_state = S_OUT;
                        end else begin
                            n_pos = r_tail;
                            n_rem = r_count;
                            if (r_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = ptr_dec(r_tail);
                                n_state = S_INS;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res   = '{ST_EMPTY, '0, '0, OCC_W'(r_count)};
                            n_state = S_OUT;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = r_head;
                            n_state = S_DEQ;
                        end
                    end
                end
            end
            S_DEQ: begin
                n_res   = '{ST_DEQ, w_rdata.id, w_rdata.prio, OCC_W'(r_count - 1'b1)};
                n_count = r_count - 1'b1;
                n_head  = ptr_inc(r_head);
                n_state = S_OUT;
            end
            S_INS: begin
                w_we = 1'b1;
                if (w_rdata.prio >= r_new.prio) begin
                    // slot found behind an equal or higher entry
                    n_count = w_count_inc;
                    n_tail  = ptr_inc(r_tail);
                    n_res   = '{ST_ENQ, '0, '0, OCC_W'(w_count_inc)};
                    n_state = S_OUT;
                end else begin
                    // move the lower entry up one slot
                    w_wdata = w_rdata;
                    n_pos   = ptr_dec(r_pos);
                    n_rem   = r_rem - 1'b1;
                    if (r_rem == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = ptr_dec(ptr_dec(r_pos));
                    end
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                n_count = w_count_inc;
                n_tail  = ptr_inc(r_tail);
                n_res   = '{ST_ENQ, '0, '0, OCC_W'(w_count_inc)};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_rem <= n_rem;
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT || r_state == S_DEQ) |-> !w_we)
        else $error("memory written outside an insert");

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("read and write of the same slot in one cycle");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ) |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not remove an entry");

endmodule

// File: bench/stable_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking bench for the stable priority queue. A scoreboard keeps its
// own sorted copy of the queue, predicts one result item per accepted request
// and checks every result field by field. Directed items cover empty, full,
// saturation and tie order. Random bursts then fill and drain the queue under
// three idling mixes, one long result hold-off and a drain between phases.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 360;
    localparam int BURST_ITEMS   = 30;
    localparam int HOLD_CYCLES   = 80;

    // Scoreboard: shadow copy of the queue and the results still awaited
    class queue_scoreboard;
        t_entry  shadow_queue[$];
        t_result awaited[$];
        int      mismatches;
        int      n_checked;
        int      n_enq;
        int      n_deq;
        int      n_empty;
        int      n_full;
        int      n_sat;

        // Work out the result of one accepted request
        function void note_request(logic op, logic [ID_W-1:0] pid,
                                   logic [PRIO_W-1:0] prio);
            t_result r;
            t_entry  e;
            int      pos;
            r.status    = ST_ENQ;
            r.id        = '0;
            r.prio      = '0;
            if (op == OP_ENQ) begin
                if (shadow_queue.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    e.id   = pid;
                    e.prio = (prio > PRIO_MAX) ? PRIO_MAX : prio;
                    if (prio > PRIO_MAX) n_sat++;
                    // after every entry of equal or higher priority
                    pos = 0;
                    while (pos < shadow_queue.size() && shadow_queue[pos].prio >= e.prio)
                        pos++;
                    shadow_queue.insert(pos, e);
                    n_enq++;
                end
            end else begin
                if (shadow_queue.size() == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    e        = shadow_queue.pop_front();
                    r.status = ST_DEQ;
                    r.id     = e.id;
                    r.prio   = e.prio;
                    n_deq++;
                end
            end
            r.occupancy = OCC_W'(shadow_queue.size());
            awaited.push_back(r);
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     n_checked, what, want, got);
            mismatches++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic [1:0] status, logic [ID_W-1:0] rid,
                          logic [PRIO_W-1:0] rprio, logic [OCC_W-1:0] occ);
            t_result want;
            if (awaited.size() == 0) begin
                report("unexpected result, status", 32'hx, 32'(status));
            end else begin
                want = awaited.pop_front();
                if (want.status !== status)
                    report("status", 32'(want.status), 32'(status));
                if (want.id !== rid)
                    report("out_id", 32'(want.id), 32'(rid));
                if (want.prio !== rprio)
                    report("out_priority", 32'(want.prio), 32'(rprio));
                if (want.occupancy !== occ)
                    report("occupancy", 32'(want.occupancy), 32'(occ));
            end
            n_checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    spq_in_if  req_if ();
    spq_out_if res_if ();

    queue_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int items_sent;

    stable_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        i_clk               = 1'b0;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_ENQ;
        req_if.process_id   <= '0;
        req_if.priority_req <= '0;
        res_if.ready        <= 1'b0;
    end

    // Offer one request item and hold it until accepted, then idle at random
    task automatic send_req(input logic op, input logic [ID_W-1:0] pid,
                            input logic [PRIO_W-1:0] prio);
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.process_id   <= pid;
        req_if.priority_req <= prio;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, pid, prio);
        items_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid        <= 1'b0;
            req_if.op           <= 1'($urandom);
            req_if.process_id   <= ID_W'($urandom);
            req_if.priority_req <= PRIO_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Random request; ties and repeated ids are made common on purpose
    task automatic send_random(input int enq_pct);
        logic              op;
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
        int                sel;
        op  = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        pid = ($urandom_range(9) < 3) ? ID_W'($urandom_range(3)) : ID_W'($urandom);
        sel = $urandom_range(9);
        if (sel < 5)      prio = PRIO_W'($urandom_range(3) * 33);
        else if (sel < 8) prio = PRIO_W'($urandom_range(100));
        else              prio = PRIO_W'($urandom_range(127));
        send_req(op, pid, prio);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check accepted items, then drive ready for the next edge
    initial begin
        int hold_left;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.status, res_if.out_id,
                                res_if.out_priority, res_if.occupancy);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results awaited",
                 STALL_LIMIT, sb.awaited.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        int enq_pct;
        send_idle_pct = 36;
        recv_idle_pct = 67;
        hold_request  = 0;
        items_sent    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty dequeue, saturation, ties, extremes, full drop
        send_req(OP_DEQ, 16'hFFFF, 7'h7F);
        send_req(OP_ENQ, 16'h0000, 7'd0);
        send_req(OP_ENQ, 16'hFFFF, 7'd100);
        send_req(OP_ENQ, 16'h1234, 7'd127);
        send_req(OP_ENQ, 16'h4321, 7'd101);
        send_req(OP_ENQ, 16'h0050, 7'd50);
        send_req(OP_ENQ, 16'h0050, 7'd50);
        send_req(OP_ENQ, 16'h0051, 7'd50);
        send_req(OP_ENQ, 16'hAAAA, 7'd0);
        send_req(OP_ENQ, 16'h5555, 7'd1);
        send_req(OP_ENQ, 16'h0001, 7'd99);
        send_req(OP_ENQ, 16'h0002, 7'd100);
        send_req(OP_ENQ, 16'h0003, 7'd64);
        send_req(OP_ENQ, 16'h8000, 7'd63);
        send_req(OP_ENQ, 16'h7FFF, 7'd0);
        send_req(OP_ENQ, 16'h0050, 7'd50);
        send_req(OP_ENQ, 16'h00FF, 7'd127);
        send_req(OP_ENQ, 16'hBEEF, 7'd100);
        send_req(OP_DEQ, 16'h0000, 7'd0);
        send_req(OP_DEQ, 16'hFFFF, 7'h7F);
        send_req(OP_DEQ, 16'h0000, 7'd0);
        wait_drained();

        // random bursts under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 67;
                recv_idle_pct = 36;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // long hold-off on results while enqueues keep coming
                hold_request = HOLD_CYCLES;
                for (int k = 0; k < 24; k++) send_random(100);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % BURST_ITEMS == 0) begin
                    case ($urandom_range(2))
                        0: enq_pct = 85;
                        1: enq_pct = 15;
                        default: enq_pct = 50;
                    endcase
                end
                send_random(enq_pct);
            end
            // pause until every result is back
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.awaited.size() != 0)
            sb.report("results never arrived, count", 32'd0, sb.awaited.size());

        $display("covered %0d requests: %0d enqueued, %0d dequeued, %0d empty, %0d full",
                 items_sent, sb.n_enq, sb.n_deq, sb.n_empty, sb.n_full);
        $display("%0d saturated priorities, three idling mixes, one long result hold-off",
                 sb.n_sat);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
